[src/mhdt_pkg.sv]
// ----------------------------------------------------------------------------
// mhdt_pkg - shared types and codes for the min-heap deadline timer
// Field widths, operation and result codes, sequencer states and words.
// ----------------------------------------------------------------------------
package mhdt_pkg;

	localparam int OP_W   = 3;
	localparam int ID_W   = 10;
	localparam int TO_W   = 31;
	localparam int DL_W   = 32;
	localparam int KIND_W = 2;

	localparam logic [OP_W-1:0] OP_ADD    = 3'd0;
	localparam logic [OP_W-1:0] OP_ADJUST = 3'd1;
	localparam logic [OP_W-1:0] OP_FIRE   = 3'd2;
	localparam logic [OP_W-1:0] OP_EXPIRE = 3'd3;
	localparam logic [OP_W-1:0] OP_POP    = 3'd4;
	localparam logic [OP_W-1:0] OP_CLEAR  = 3'd5;

	localparam logic [KIND_W-1:0] KIND_FIRED  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_NEXT   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_DONE   = 2'd2;
	localparam logic [KIND_W-1:0] KIND_REJECT = 2'd3;

	typedef enum logic [3:0] {
		S_IDLE,
		S_LOOKUP,
		S_CHECK,
		S_EX_RD,
		S_EX_CHK,
		S_RM_TAIL,
		S_RM_LOAD,
		S_SD_RD,
		S_SD_PICK,
		S_SD_CMP,
		S_SU_RD,
		S_SU_CMP,
		S_DR_RD,
		S_DR_SEND,
		S_DR_FIN
	} state_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [ID_W-1:0]   result_id;
		logic [TO_W-1:0]   remaining_ms;
		logic              heap_empty;
		logic              last;
	} rsp_word_t;

	typedef struct packed {
		logic [DL_W-1:0] diff;
		logic            earlier;
		logic            due;
	} cmp_res_t;

endpackage

[src/mhdt_cmd_if.sv]
// ----------------------------------------------------------------------------
// mhdt_cmd_if - command channel
// Valid/ready channel carrying one timer command word.
// ----------------------------------------------------------------------------
interface mhdt_cmd_if;
	import mhdt_pkg::*;

	logic            valid;
	logic            ready;
	logic [OP_W-1:0] op;
	logic [ID_W-1:0] timer_id;
	logic [TO_W-1:0] timeout_ms;
	logic [DL_W-1:0] now_ms;

	modport source (output valid, op, timer_id, timeout_ms, now_ms, input ready);
	modport sink   (input valid, op, timer_id, timeout_ms, now_ms, output ready);
endinterface

[src/mhdt_rsp_if.sv]
// ----------------------------------------------------------------------------
// mhdt_rsp_if - response channel
// Valid/ready channel carrying one timer result word.
// ----------------------------------------------------------------------------
interface mhdt_rsp_if;
	import mhdt_pkg::*;

	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [ID_W-1:0]   result_id;
	logic [TO_W-1:0]   remaining_ms;
	logic              heap_empty;
	logic              last;

	modport source (output valid, kind, result_id, remaining_ms, heap_empty, last,
		input ready);
	modport sink   (input valid, kind, result_id, remaining_ms, heap_empty, last,
		output ready);
endinterface

[src/mhdt_cmp_unit.sv]
// ----------------------------------------------------------------------------
// mhdt_cmp_unit - shared deadline comparator
// One 32-bit wrap subtractor: a earlier than b, and a not after b.
// ----------------------------------------------------------------------------
module mhdt_cmp_unit (
	input  logic [mhdt_pkg::DL_W-1:0] a,
	input  logic [mhdt_pkg::DL_W-1:0] b,
	output mhdt_pkg::cmp_res_t        res
);
	import mhdt_pkg::*;

	logic [DL_W-1:0] diff;

	assign diff        = a - b;
	assign res.diff    = diff;
	assign res.earlier = diff[DL_W-1];
	assign res.due     = diff[DL_W-1] || (diff == '0);
endmodule

[src/mhdt_out_stage.sv]
// ----------------------------------------------------------------------------
// mhdt_out_stage - response output register
// Holds one result word until the receiver takes it.
// ----------------------------------------------------------------------------
module mhdt_out_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  mhdt_pkg::rsp_word_t word,
	output logic                free,
	mhdt_rsp_if.source          rsp
);
	import mhdt_pkg::*;

	logic      valid_q;
	rsp_word_t word_q;

	assign free = !valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (rsp.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			word_q <= word;
		end
	end

	assign rsp.valid        = valid_q;
	assign rsp.kind         = word_q.kind;
	assign rsp.result_id    = word_q.result_id;
	assign rsp.remaining_ms = word_q.remaining_ms;
	assign rsp.heap_empty   = word_q.heap_empty;
	assign rsp.last         = word_q.last;
endmodule

[src/min_heap_deadline_timer_core.sv]
// ----------------------------------------------------------------------------
// min_heap_deadline_timer_core - binary min-heap timer queue
// Heap of (id, deadline) with an id-to-slot map, walked by a small sequencer.
// ----------------------------------------------------------------------------
// cmd: one command word (op, timer_id, timeout_ms, now_ms), taken when valid
// and ready are high. ready is high only while the sequencer is idle.
// rsp: one or more result words per command; the final one has last set.
// All words of a command carry the heap_empty value seen after the command.
// Sequence: lookup runs through S_LOOKUP and S_CHECK after acceptance; each
// heap level of a sift passes S_SU_RD and S_SU_CMP going up and S_SD_RD,
// S_SD_PICK and S_SD_CMP going down through the single heap RAM read pair.
// An expire command repeats a root removal per due timer. Results then drain
// word by word via S_DR_RD and S_DR_SEND; S_DR_FIN sends the final word.
// When rsp stalls, the sequencer holds the word and waits; the next command
// is taken once the final word sits in the output register.
// Reset empties the queue at once; heap and map RAMs need no clearing since
// a slot counts only if it lies below the entry count and holds the id.
// ----------------------------------------------------------------------------
module min_heap_deadline_timer_core #(
	parameter int CAPACITY = 32,
	parameter int ID_COUNT = 1024
) (
	input  logic       clk,
	input  logic       arst_n,
	mhdt_cmd_if.sink   cmd,
	mhdt_rsp_if.source rsp
);
	import mhdt_pkg::*;

	localparam int PW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int JW = PW + 1;
	localparam int IW = (ID_COUNT > 1) ? $clog2(ID_COUNT) : 1;
	localparam int HW = ID_W + DL_W;

	// storage
	logic [HW-1:0]   heap_mem [CAPACITY];
	logic [PW-1:0]   pos_mem  [ID_COUNT];
	logic [ID_W-1:0] buf_mem  [CAPACITY];

	state_t          state_q, state_d;
	logic [CW-1:0]   count_q, count_d;
	logic [CW-1:0]   buf_cnt_q, buf_cnt_d;
	logic [CW-1:0]   rd_idx_q, rd_idx_d;

	logic [OP_W-1:0] op_q, op_d;
	logic [ID_W-1:0] id_q, id_d;
	logic [DL_W-1:0] dl_q, dl_d;
	logic [DL_W-1:0] now_q, now_d;
	logic [ID_W-1:0] cur_id_q, cur_id_d;
	logic [DL_W-1:0] cur_dl_q, cur_dl_d;
	logic [PW-1:0]   i_q, i_d;
	logic            moved_q, moved_d;
	logic            up_ok_q, up_ok_d;
	logic [ID_W-1:0] ch_id_q, ch_id_d;
	logic [DL_W-1:0] ch_dl_q, ch_dl_d;
	logic [PW-1:0]   ch_pos_q, ch_pos_d;
	logic [KIND_W-1:0] fin_kind_q, fin_kind_d;
	logic [ID_W-1:0] fin_id_q, fin_id_d;
	logic [TO_W-1:0] fin_rem_q, fin_rem_d;

	// memory ports
	logic            h_rd_en;
	logic [PW-1:0]   ha_addr, hb_addr;
	logic [HW-1:0]   rd_a_q, rd_b_q;
	logic            hw_en;
	logic [PW-1:0]   hw_addr;
	logic [HW-1:0]   hw_data;
	logic            pr_en;
	logic [IW-1:0]   pr_addr;
	logic [PW-1:0]   pos_rd_q;
	logic            pw_en;
	logic [IW-1:0]   pw_addr;
	logic [PW-1:0]   pw_data;
	logic            bw_en;
	logic            br_en;
	logic [ID_W-1:0] buf_rd_q;

	logic [ID_W-1:0] rda_id, rdb_id;
	logic [DL_W-1:0] rda_dl, rdb_dl;
	logic [JW-1:0]   j_lo, j_hi, cnt_j;
	logic [CW-1:0]   n_w;
	logic [PW-1:0]   parent;
	logic            present, id_ok, heap_empty;

	logic [DL_W-1:0] cmp_a, cmp_b;
	cmp_res_t        cmp;

	logic            out_free, ld;
	rsp_word_t       ld_word;

	assign rda_id     = rd_a_q[HW-1:DL_W];
	assign rda_dl     = rd_a_q[DL_W-1:0];
	assign rdb_id     = rd_b_q[HW-1:DL_W];
	assign rdb_dl     = rd_b_q[DL_W-1:0];
	assign j_lo       = {i_q, 1'b1};
	assign j_hi       = j_lo + 1'b1;
	assign cnt_j      = JW'(count_q);
	assign n_w        = count_q - 1'b1;
	assign parent     = (i_q - 1'b1) >> 1;
	assign present    = ({1'b0, pos_rd_q} < cnt_j) && (rda_id == id_q);
	assign id_ok      = 32'(id_q) < 32'(ID_COUNT);
	assign heap_empty = (count_q == '0);
	assign cmd.ready  = (state_q == S_IDLE);

	mhdt_cmp_unit u_cmp (
		.a   (cmp_a),
		.b   (cmp_b),
		.res (cmp)
	);

	mhdt_out_stage u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (ld),
		.word   (ld_word),
		.free   (out_free),
		.rsp    (rsp)
	);

	always_comb begin
		unique case (state_q)
			S_SD_PICK: begin
				cmp_a = rdb_dl;
				cmp_b = rda_dl;
			end
			S_SU_CMP: begin
				cmp_a = rda_dl;
				cmp_b = cur_dl_q;
			end
			S_EX_CHK: begin
				cmp_a = rda_dl;
				cmp_b = now_q;
			end
			default: begin
				cmp_a = cur_dl_q;
				cmp_b = ch_dl_q;
			end
		endcase
	end

	always_comb begin
		state_d    = state_q;
		count_d    = count_q;
		buf_cnt_d  = buf_cnt_q;
		rd_idx_d   = rd_idx_q;
		op_d       = op_q;
		id_d       = id_q;
		dl_d       = dl_q;
		now_d      = now_q;
		cur_id_d   = cur_id_q;
		cur_dl_d   = cur_dl_q;
		i_d        = i_q;
		moved_d    = moved_q;
		up_ok_d    = up_ok_q;
		ch_id_d    = ch_id_q;
		ch_dl_d    = ch_dl_q;
		ch_pos_d   = ch_pos_q;
		fin_kind_d = fin_kind_q;
		fin_id_d   = fin_id_q;
		fin_rem_d  = fin_rem_q;
		h_rd_en    = 1'b0;
		ha_addr    = '0;
		hb_addr    = '0;
		hw_en      = 1'b0;
		hw_addr    = i_q;
		hw_data    = {cur_id_q, cur_dl_q};
		pr_en      = 1'b0;
		pr_addr    = IW'(cmd.timer_id);
		pw_en      = 1'b0;
		pw_addr    = IW'(cur_id_q);
		pw_data    = i_q;
		bw_en      = 1'b0;
		br_en      = 1'b0;
		ld         = 1'b0;
		ld_word    = '{KIND_FIRED, buf_rd_q, '0, heap_empty, 1'b0};

		unique case (state_q)
			S_IDLE: begin
				if (cmd.valid) begin
					op_d      = cmd.op;
					id_d      = cmd.timer_id;
					dl_d      = cmd.now_ms + {1'b0, cmd.timeout_ms};
					now_d     = cmd.now_ms;
					buf_cnt_d = '0;
					rd_idx_d  = '0;
					pr_en     = 1'b1;
					state_d   = S_LOOKUP;
				end
			end
			S_LOOKUP: begin
				h_rd_en = 1'b1;
				ha_addr = pos_rd_q;
				state_d = S_CHECK;
			end
			S_CHECK: begin
				fin_kind_d = KIND_DONE;
				fin_id_d   = id_q;
				fin_rem_d  = '0;
				state_d    = S_DR_RD;
				cur_id_d   = id_q;
				cur_dl_d   = dl_q;
				moved_d    = 1'b0;
				if (op_q <= OP_FIRE && !id_ok) begin
					fin_kind_d = KIND_REJECT;
				end else begin
					unique case (op_q)
						OP_ADD: begin
							if (present) begin
								i_d     = pos_rd_q;
								up_ok_d = 1'b1;
								state_d = S_SD_RD;
							end else if (count_q == CW'(CAPACITY)) begin
								fin_kind_d = KIND_REJECT;
							end else begin
								i_d     = PW'(count_q);
								count_d = count_q + 1'b1;
								state_d = S_SU_RD;
							end
						end
						OP_ADJUST: begin
							if (present) begin
								i_d     = pos_rd_q;
								up_ok_d = 1'b0;
								state_d = S_SD_RD;
							end
						end
						OP_FIRE: begin
							if (present) begin
								fin_kind_d = KIND_FIRED;
								i_d        = pos_rd_q;
								state_d    = S_RM_TAIL;
							end
						end
						OP_EXPIRE, OP_POP: begin
							state_d = S_EX_RD;
						end
						OP_CLEAR: begin
							count_d = '0;
						end
						default: begin
							fin_kind_d = KIND_REJECT;
						end
					endcase
				end
			end
			S_EX_RD: begin
				if (heap_empty) begin
					fin_kind_d = KIND_DONE;
					fin_id_d   = id_q;
					fin_rem_d  = '0;
					state_d    = S_DR_RD;
				end else begin
					h_rd_en = 1'b1;
					state_d = S_EX_CHK;
				end
			end
			S_EX_CHK: begin
				i_d = '0;
				if (op_q == OP_POP) begin
					fin_kind_d = KIND_FIRED;
					fin_id_d   = rda_id;
					state_d    = S_RM_TAIL;
				end else if (cmp.due) begin
					bw_en     = 1'b1;
					buf_cnt_d = buf_cnt_q + 1'b1;
					state_d   = S_RM_TAIL;
				end else begin
					fin_kind_d = KIND_NEXT;
					fin_id_d   = rda_id;
					fin_rem_d  = cmp.diff[TO_W-1:0];
					state_d    = S_DR_RD;
				end
			end
			S_RM_TAIL: begin
				count_d = n_w;
				if (CW'(i_q) == n_w) begin
					state_d = (op_q == OP_EXPIRE) ? S_EX_RD : S_DR_RD;
				end else begin
					h_rd_en = 1'b1;
					ha_addr = PW'(n_w);
					state_d = S_RM_LOAD;
				end
			end
			S_RM_LOAD: begin
				cur_id_d = rda_id;
				cur_dl_d = rda_dl;
				moved_d  = 1'b0;
				up_ok_d  = 1'b1;
				state_d  = S_SD_RD;
			end
			S_SD_RD: begin
				if (j_lo >= cnt_j) begin
					hw_en = 1'b1;
					pw_en = 1'b1;
					if (moved_q || !up_ok_q) begin
						state_d = (op_q == OP_EXPIRE) ? S_EX_RD : S_DR_RD;
					end else begin
						state_d = S_SU_RD;
					end
				end else begin
					h_rd_en = 1'b1;
					ha_addr = PW'(j_lo);
					hb_addr = PW'(j_hi);
					state_d = S_SD_PICK;
				end
			end
			S_SD_PICK: begin
				if (j_hi < cnt_j && cmp.earlier) begin
					ch_id_d  = rdb_id;
					ch_dl_d  = rdb_dl;
					ch_pos_d = PW'(j_hi);
				end else begin
					ch_id_d  = rda_id;
					ch_dl_d  = rda_dl;
					ch_pos_d = PW'(j_lo);
				end
				state_d = S_SD_CMP;
			end
			S_SD_CMP: begin
				if (cmp.earlier) begin
					hw_en = 1'b1;
					pw_en = 1'b1;
					if (moved_q || !up_ok_q) begin
						state_d = (op_q == OP_EXPIRE) ? S_EX_RD : S_DR_RD;
					end else begin
						state_d = S_SU_RD;
					end
				end else begin
					hw_en   = 1'b1;
					hw_data = {ch_id_q, ch_dl_q};
					pw_en   = 1'b1;
					pw_addr = IW'(ch_id_q);
					i_d     = ch_pos_q;
					moved_d = 1'b1;
					state_d = S_SD_RD;
				end
			end
			S_SU_RD: begin
				if (i_q == '0) begin
					hw_en   = 1'b1;
					pw_en   = 1'b1;
					state_d = (op_q == OP_EXPIRE) ? S_EX_RD : S_DR_RD;
				end else begin
					h_rd_en = 1'b1;
					ha_addr = parent;
					state_d = S_SU_CMP;
				end
			end
			S_SU_CMP: begin
				hw_en = 1'b1;
				pw_en = 1'b1;
				if (cmp.earlier) begin
					state_d = (op_q == OP_EXPIRE) ? S_EX_RD : S_DR_RD;
				end else begin
					hw_data = rd_a_q;
					pw_addr = IW'(rda_id);
					i_d     = parent;
					state_d = S_SU_RD;
				end
			end
			S_DR_RD: begin
				if (rd_idx_q == buf_cnt_q) begin
					state_d = S_DR_FIN;
				end else begin
					br_en   = 1'b1;
					state_d = S_DR_SEND;
				end
			end
			S_DR_SEND: begin
				if (out_free) begin
					ld       = 1'b1;
					rd_idx_d = rd_idx_q + 1'b1;
					state_d  = S_DR_RD;
				end
			end
			S_DR_FIN: begin
				ld_word = '{fin_kind_q, fin_id_q, fin_rem_q, heap_empty, 1'b1};
				if (out_free) begin
					ld      = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			buf_cnt_q <= '0;
			rd_idx_q  <= '0;
		end else begin
			state_q   <= state_d;
			count_q   <= count_d;
			buf_cnt_q <= buf_cnt_d;
			rd_idx_q  <= rd_idx_d;
		end
	end

	always_ff @(posedge clk) begin
		op_q       <= op_d;
		id_q       <= id_d;
		dl_q       <= dl_d;
		now_q      <= now_d;
		cur_id_q   <= cur_id_d;
		cur_dl_q   <= cur_dl_d;
		i_q        <= i_d;
		moved_q    <= moved_d;
		up_ok_q    <= up_ok_d;
		ch_id_q    <= ch_id_d;
		ch_dl_q    <= ch_dl_d;
		ch_pos_q   <= ch_pos_d;
		fin_kind_q <= fin_kind_d;
		fin_id_q   <= fin_id_d;
		fin_rem_q  <= fin_rem_d;
	end

	// heap RAM: two registered reads, one write
	always_ff @(posedge clk) begin
		if (h_rd_en) begin
			rd_a_q <= heap_mem[ha_addr];
			rd_b_q <= heap_mem[hb_addr];
		end
		if (hw_en) begin
			heap_mem[hw_addr] <= hw_data;
		end
	end

	// id-to-slot map
	always_ff @(posedge clk) begin
		if (pr_en) begin
			pos_rd_q <= pos_mem[pr_addr];
		end
		if (pw_en) begin
			pos_mem[pw_addr] <= pw_data;
		end
	end

	// expired id buffer
	always_ff @(posedge clk) begin
		if (br_en) begin
			buf_rd_q <= buf_mem[PW'(rd_idx_q)];
		end
		if (bw_en) begin
			buf_mem[PW'(buf_cnt_q)] <= rda_id;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("entry count beyond capacity");

	a_buf_bound: assert property (@(posedge clk) disable iff (!arst_n)
		buf_cnt_q <= CW'(CAPACITY))
		else $error("expired buffer overrun");

	a_child_live: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SD_CMP) |-> ({1'b0, ch_pos_q} < cnt_j))
		else $error("sift child beyond heap tail");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		(ld && rsp.valid) |-> rsp.ready)
		else $error("result word overwritten while held");

	a_drain_only: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_idx_q != '0) |-> (rd_idx_q <= buf_cnt_q))
		else $error("drain index past buffered words");
endmodule

[test/mhdt_scoreboard.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhdt_scoreboard - heap timer predictor and result checker
// Keeps its own min-heap of timers, works out the result words of each
// accepted command and compares result words with them in order.
// ----------------------------------------------------------------------------
class mhdt_scoreboard;
	localparam int CAP = 32;
	localparam int IDS = 1024;

	logic [9:0]  slot_id [CAP];
	logic [31:0] slot_dl [CAP];
	int          where_is [IDS];
	bit          armed [IDS];
	int          fill;
	mhdt_pkg::rsp_word_t pending_words[$];
	int          errors;

	function new();
		fill = 0;
		errors = 0;
		foreach (armed[i]) armed[i] = 0;
	endfunction

	function int count();
		return fill;
	endfunction

	function bit is_armed(int id);
		return armed[id];
	endfunction

	function bit sooner(logic [31:0] a, logic [31:0] b);
		logic [31:0] d;
		d = a - b;
		return d[31];
	endfunction

	function void swap_slots(int i, int j);
		logic [9:0]  t_id;
		logic [31:0] t_dl;
		t_id = slot_id[i];
		t_dl = slot_dl[i];
		slot_id[i] = slot_id[j];
		slot_dl[i] = slot_dl[j];
		slot_id[j] = t_id;
		slot_dl[j] = t_dl;
		where_is[slot_id[i]] = i;
		where_is[slot_id[j]] = j;
	endfunction

	function void bubble_up(int i);
		int p;
		while (i > 0) begin
			p = (i - 1) / 2;
			if (sooner(slot_dl[p], slot_dl[i]))
				break;
			swap_slots(i, p);
			i = p;
		end
	endfunction

	function bit sink_down(int start, int n);
		int i;
		int j;
		i = start;
		j = 2 * i + 1;
		while (j < n) begin
			if (j + 1 < n && sooner(slot_dl[j + 1], slot_dl[j]))
				j++;
			if (sooner(slot_dl[i], slot_dl[j]))
				break;
			swap_slots(i, j);
			i = j;
			j = 2 * i + 1;
		end
		return i > start;
	endfunction

	function void take_out(int i);
		int n;
		if (fill == 0 || i >= fill)
			return;
		n = fill - 1;
		if (i < n) begin
			swap_slots(i, n);
			if (!sink_down(i, n))
				bubble_up(i);
		end
		armed[slot_id[n]] = 0;
		fill = n;
	endfunction

	function void note_command(logic [2:0] op, logic [9:0] id, logic [30:0] tmo,
			logic [31:0] now);
		mhdt_pkg::rsp_word_t w[$];
		mhdt_pkg::rsp_word_t r;
		logic [31:0] dl;
		logic [31:0] diff;
		int pos;
		dl = now + {1'b0, tmo};
		r = '0;
		r.result_id = id;
		r.kind = mhdt_pkg::KIND_DONE;
		case (op)
			mhdt_pkg::OP_ADD: begin
				if (armed[id]) begin
					pos = where_is[id];
					slot_dl[pos] = dl;
					if (!sink_down(pos, fill))
						bubble_up(pos);
				end else if (fill >= CAP) begin
					r.kind = mhdt_pkg::KIND_REJECT;
				end else begin
					slot_id[fill] = id;
					slot_dl[fill] = dl;
					where_is[id] = fill;
					armed[id] = 1;
					fill++;
					bubble_up(fill - 1);
				end
				w = {w, r};
			end
			mhdt_pkg::OP_ADJUST: begin
				if (armed[id]) begin
					pos = where_is[id];
					slot_dl[pos] = dl;
					void'(sink_down(pos, fill));
				end
				w = {w, r};
			end
			mhdt_pkg::OP_FIRE: begin
				if (armed[id]) begin
					r.kind = mhdt_pkg::KIND_FIRED;
					take_out(where_is[id]);
				end
				w = {w, r};
			end
			mhdt_pkg::OP_EXPIRE: begin
				while (fill > 0) begin
					diff = slot_dl[0] - now;
					if (diff != 0 && !diff[31])
						break;
					r.kind = mhdt_pkg::KIND_FIRED;
					r.result_id = slot_id[0];
					w = {w, r};
					take_out(0);
				end
				r.result_id = id;
				r.kind = mhdt_pkg::KIND_DONE;
				if (fill > 0) begin
					diff = slot_dl[0] - now;
					r.kind = mhdt_pkg::KIND_NEXT;
					r.result_id = slot_id[0];
					r.remaining_ms = diff[30:0];
				end
				w = {w, r};
			end
			mhdt_pkg::OP_POP: begin
				if (fill > 0) begin
					r.kind = mhdt_pkg::KIND_FIRED;
					r.result_id = slot_id[0];
					take_out(0);
				end
				w = {w, r};
			end
			mhdt_pkg::OP_CLEAR: begin
				foreach (armed[i]) armed[i] = 0;
				fill = 0;
				w = {w, r};
			end
			default: begin
				r.kind = mhdt_pkg::KIND_REJECT;
				w = {w, r};
			end
		endcase
		foreach (w[k]) begin
			w[k].heap_empty = (fill == 0);
			w[k].last = (k == w.size() - 1);
			pending_words = {pending_words, w[k]};
		end
	endfunction

	task report(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %0h want %0h", what, got, want);
		errors++;
	endtask

	task check_word(mhdt_pkg::rsp_word_t got);
		mhdt_pkg::rsp_word_t want;
		if (pending_words.size() == 0) begin
			report("unexpected word id", 32'(got.result_id), 32'd0);
			return;
		end
		want = pending_words.pop_front();
		if (got.kind !== want.kind) report("kind", got.kind, want.kind);
		if (got.result_id !== want.result_id) report("id", got.result_id, want.result_id);
		if (got.remaining_ms !== want.remaining_ms)
			report("remaining", got.remaining_ms, want.remaining_ms);
		if (got.heap_empty !== want.heap_empty)
			report("empty", got.heap_empty, want.heap_empty);
		if (got.last !== want.last) report("last", got.last, want.last);
	endtask
endclass

[test/min_heap_deadline_timer_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_heap_deadline_timer_core_tb - self-checking bench for the timer heap
// Directed corner commands, then random bursts of arms, re-arms, fires and
// expiry sweeps with random gaps and receiver stalls, checked word by word.
// ----------------------------------------------------------------------------
module min_heap_deadline_timer_core_tb;
	import mhdt_pkg::*;

	logic clk;
	logic arst_n;
	mhdt_cmd_if cmd ();
	mhdt_rsp_if rsp ();

	mhdt_scoreboard heap_model;
	bit             long_hold;
	logic [31:0]    clock_ms;
	int             n_sent;

	min_heap_deadline_timer_core dut (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd.sink),
		.rsp   (rsp.source)
	);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	initial begin
		#50_000_000;
		$display("min_heap_deadline_timer_core test failed");
		$finish;
	end

	function int gap_len();
		if ($urandom_range(0, 2) == 0) return 0;
		if ($urandom_range(0, 15) == 0) return $urandom_range(10, 40);
		return $urandom_range(0, 3);
	endfunction

	task automatic send_cmd(logic [2:0] op, logic [9:0] id, logic [30:0] tmo,
			logic [31:0] now);
		int g;
		g = gap_len();
		if (g > 0) begin
			cmd.valid <= 0;
			repeat (g) @(posedge clk);
		end
		cmd.valid <= 1;
		cmd.op <= op;
		cmd.timer_id <= id;
		cmd.timeout_ms <= tmo;
		cmd.now_ms <= now;
		do @(posedge clk); while (!cmd.ready);
		heap_model.note_command(op, id, tmo, now);
		n_sent++;
	endtask

	task automatic wait_drained();
		cmd.valid <= 0;
		@(posedge clk);
		while (heap_model.pending_words.size() != 0) @(posedge clk);
	endtask

	// keeps ids in a small pool so re-arms and fires hit live timers
	function logic [9:0] pick_id();
		if ($urandom_range(0, 9) == 0) return 10'($urandom_range(0, 1023));
		return 10'($urandom_range(0, 40));
	endfunction

	task automatic random_cmd();
		int sel;
		logic [2:0] op;
		logic [30:0] tmo;
		sel = $urandom_range(0, 99);
		if (sel < 45) op = OP_ADD;
		else if (sel < 55) op = OP_ADJUST;
		else if (sel < 68) op = OP_FIRE;
		else if (sel < 85) op = OP_EXPIRE;
		else if (sel < 93) op = OP_POP;
		else if (sel < 95) op = OP_CLEAR;
		else op = 3'($urandom_range(6, 7));
		case ($urandom_range(0, 5))
			0: tmo = 31'($urandom);
			1: tmo = '0;
			default: tmo = 31'($urandom_range(0, 500));
		endcase
		clock_ms = clock_ms + $urandom_range(0, 120);
		send_cmd(op, pick_id(), tmo, clock_ms);
	endtask

	initial begin
		int g;
		rsp.ready = 0;
		forever begin
			@(posedge clk);
			if (long_hold) begin
				rsp.ready <= 0;
				repeat (300) @(posedge clk);
				long_hold = 0;
				rsp.ready <= 1;
			end else begin
				g = gap_len();
				if ($urandom_range(0, 3) == 0 && g > 0) begin
					rsp.ready <= 0;
					repeat (g) @(posedge clk);
				end
				rsp.ready <= 1;
			end
		end
	end

	always @(posedge clk)
		if (arst_n && rsp.valid && rsp.ready)
			heap_model.check_word({rsp.kind, rsp.result_id, rsp.remaining_ms,
				rsp.heap_empty, rsp.last});

	initial begin
		heap_model = new();
		long_hold = 0;
		n_sent = 0;
		cmd.valid = 0;
		cmd.op = OP_ADD;
		cmd.timer_id = 0;
		cmd.timeout_ms = 0;
		cmd.now_ms = 0;
		arst_n = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// empty heap, absent ids, undefined ops
		send_cmd(OP_POP, 10'd0, 31'd0, 32'd0);
		send_cmd(OP_EXPIRE, 10'h3FF, 31'h7FFFFFFF, 32'hFFFFFFFF);
		send_cmd(OP_FIRE, 10'd5, 31'd0, 32'd0);
		send_cmd(OP_ADJUST, 10'd5, 31'd7, 32'd0);
		send_cmd(3'd6, 10'h2AA, 31'h55555555, 32'hAAAAAAAA);
		send_cmd(3'd7, 10'h155, 31'h2AAAAAAA, 32'h55555555);
		// deadlines across the wrap point
		send_cmd(OP_ADD, 10'h3FF, 31'h7FFFFFFF, 32'hFFFFFFF0);
		send_cmd(OP_ADD, 10'd0, 31'd0, 32'hFFFFFFF0);
		send_cmd(OP_ADD, 10'd1, 31'd100, 32'hFFFFFFF0);
		send_cmd(OP_ADD, 10'd1, 31'd2, 32'hFFFFFFF0);
		send_cmd(OP_ADJUST, 10'd0, 31'd500, 32'hFFFFFFF0);
		send_cmd(OP_EXPIRE, 10'd0, 31'd0, 32'hFFFFFFF2);
		send_cmd(OP_FIRE, 10'h3FF, 31'd0, 32'd0);
		send_cmd(OP_POP, 10'd0, 31'd0, 32'd0);
		// fill to capacity, reject one more, then sweep all due
		for (int i = 0; i < 33; i++)
			send_cmd(OP_ADD, 10'(100 + i), 31'($urandom_range(0, 50)), 32'd1000);
		send_cmd(OP_ADD, 10'd100, 31'd3, 32'd1000);
		send_cmd(OP_EXPIRE, 10'd0, 31'd0, 32'd1100);
		send_cmd(OP_ADD, 10'd7, 31'd9, 32'd0);
		send_cmd(OP_CLEAR, 10'd0, 31'd0, 32'd0);
		send_cmd(OP_EXPIRE, 10'd0, 31'd0, 32'd0);

		// long receiver stall while commands keep coming
		clock_ms = 32'hFFFFF000;
		long_hold = 1;
		repeat (20) random_cmd();
		// sender pause until the result queue empties
		wait_drained();
		while (n_sent < 109) random_cmd();
		// finish with a full sweep so big expiry bursts occur
		send_cmd(OP_EXPIRE, 10'd0, 31'd0, clock_ms + 32'h40000000);

		wait_drained();
		repeat (100) @(posedge clk);
		if (heap_model.errors == 0 && heap_model.pending_words.size() == 0)
			$display("min_heap_deadline_timer_core test passed");
		else
			$display("min_heap_deadline_timer_core test failed");
		$finish;
	end
endmodule

[files.f]
src/mhdt_pkg.sv
src/mhdt_cmd_if.sv
src/mhdt_rsp_if.sv
src/mhdt_cmp_unit.sv
src/mhdt_out_stage.sv
src/min_heap_deadline_timer_core.sv
test/mhdt_scoreboard.sv
test/min_heap_deadline_timer_core_tb.sv
